// ===== sv/ea6502_pkg.sv =====
`default_nettype none

package ea6502_pkg;

  // Addressing forms
  localparam logic [3:0] FORM_IMPLIED   = 4'd0;
  localparam logic [3:0] FORM_ACCUM     = 4'd1;
  localparam logic [3:0] FORM_IMM       = 4'd2;
  localparam logic [3:0] FORM_ZP        = 4'd3;
  localparam logic [3:0] FORM_ZP_X      = 4'd4;
  localparam logic [3:0] FORM_ZP_Y      = 4'd5;
  localparam logic [3:0] FORM_ABS       = 4'd6;
  localparam logic [3:0] FORM_ABS_X     = 4'd7;
  localparam logic [3:0] FORM_ABS_Y     = 4'd8;
  localparam logic [3:0] FORM_REL       = 4'd9;
  localparam logic [3:0] FORM_IND       = 4'd10;
  localparam logic [3:0] FORM_IND_X     = 4'd11;
  localparam logic [3:0] FORM_IND_Y     = 4'd12;

  // Transaction modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_FINAL = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Indirect sequencing phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LOW  = 3'b010,
    PH_HIGH = 3'b100
  } phase_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  address_form;
    logic [15:0] operand;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  accumulator;
    logic [15:0] program_counter;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] address;
    logic        extra_cycles;
    logic [1:0]  instruction_length;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  pending_form;
    phase_t      phase;
    logic [15:0] pointer;
    logic [7:0]  low_byte;
    logic [7:0]  held_y;
  } ea_state_t;

  // Instruction length in bytes for a form
  function automatic logic [1:0] form_length(input logic [3:0] form);
    logic [1:0] len;
    case (form) inside
      FORM_IMM, FORM_ZP, FORM_ZP_X, FORM_ZP_Y, FORM_REL, FORM_IND_X, FORM_IND_Y:
        len = 2'd2;
      FORM_ABS, FORM_ABS_X, FORM_ABS_Y, FORM_IND:
        len = 2'd3;
      default:
        len = 2'd1;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ea6502_calc.sv =====
`default_nettype none

module ea6502_calc (
  input  ea6502_pkg::in_item_t  item,
  input  ea6502_pkg::ea_state_t state_cur,
  output ea6502_pkg::out_item_t result,
  output ea6502_pkg::ea_state_t state_nxt
);

  logic [7:0]  op8;
  logic [1:0]  len;
  logic [1:0]  plen;
  logic [15:0] abs_x_sum;
  logic [15:0] abs_y_sum;
  logic [15:0] rel_sum;
  logic [15:0] base;
  logic [15:0] base_y_sum;
  logic [7:0]  zp_x_sum;

  // Shared address arithmetic
  assign op8        = item.operand[7:0];
  assign len        = ea6502_pkg::form_length(item.address_form);
  assign plen       = ea6502_pkg::form_length(state_cur.pending_form);
  assign abs_x_sum  = item.operand + {8'd0, item.index_x};
  assign abs_y_sum  = item.operand + {8'd0, item.index_y};
  assign rel_sum    = item.program_counter + {{8{op8[7]}}, op8};
  assign base       = {item.read_data, state_cur.low_byte};
  assign base_y_sum = base + {8'd0, state_cur.held_y};
  assign zp_x_sum   = op8 + item.index_x;

  always_comb begin
    state_nxt = state_cur;
    result    = '{result_kind: ea6502_pkg::KIND_FINAL, address: 16'd0,
                  extra_cycles: 1'b0, instruction_length: 2'd1};

    if (item.mode == ea6502_pkg::MODE_DATA) begin
      // Returned byte of an indirect pointer
      unique case (state_cur.phase)
        ea6502_pkg::PH_LOW: begin
          state_nxt.low_byte = item.read_data;
          state_nxt.phase    = ea6502_pkg::PH_HIGH;
          result.result_kind = ea6502_pkg::KIND_READ;
          // high byte stays in the same page
          result.address     = {state_cur.pointer[15:8], state_cur.pointer[7:0] + 8'd1};
          result.instruction_length = plen;
        end
        ea6502_pkg::PH_HIGH: begin
          state_nxt.phase    = ea6502_pkg::PH_IDLE;
          result.result_kind = ea6502_pkg::KIND_FINAL;
          result.instruction_length = plen;
          if (state_cur.pending_form == ea6502_pkg::FORM_IND_Y) begin
            result.address      = base_y_sum;
            result.extra_cycles = (base_y_sum[15:8] != base[15:8]);
          end else begin
            result.address = base;
          end
        end
        default: begin
          // data with nothing pending
          result.result_kind = ea6502_pkg::KIND_ERROR;
        end
      endcase
    end else begin
      // New resolution; any pending one is dropped
      state_nxt.phase = ea6502_pkg::PH_IDLE;
      result.instruction_length = len;
      case (item.address_form) inside
        ea6502_pkg::FORM_ACCUM: result.address = {8'd0, item.accumulator};
        ea6502_pkg::FORM_IMM,
        ea6502_pkg::FORM_ZP:    result.address = {8'd0, op8};
        ea6502_pkg::FORM_ZP_X: begin
          result.address      = {8'd0, zp_x_sum};
          result.extra_cycles = 1'b1;
        end
        ea6502_pkg::FORM_ZP_Y: begin
          result.address      = {8'd0, op8 + item.index_y};
          result.extra_cycles = 1'b1;
        end
        ea6502_pkg::FORM_ABS:   result.address = item.operand;
        ea6502_pkg::FORM_ABS_X: begin
          result.address      = abs_x_sum;
          result.extra_cycles = (abs_x_sum[15:8] != item.operand[15:8]);
        end
        ea6502_pkg::FORM_ABS_Y: begin
          result.address      = abs_y_sum;
          result.extra_cycles = (abs_y_sum[15:8] != item.operand[15:8]);
        end
        ea6502_pkg::FORM_REL:   result.address = rel_sum;
        ea6502_pkg::FORM_IND,
        ea6502_pkg::FORM_IND_X,
        ea6502_pkg::FORM_IND_Y: begin
          state_nxt.pending_form = item.address_form;
          state_nxt.held_y       = item.index_y;
          state_nxt.phase        = ea6502_pkg::PH_LOW;
          if (item.address_form == ea6502_pkg::FORM_IND) begin
            state_nxt.pointer = item.operand;
          end else if (item.address_form == ea6502_pkg::FORM_IND_X) begin
            state_nxt.pointer = {8'd0, zp_x_sum};
          end else begin
            state_nxt.pointer = {8'd0, op8};
          end
          result.result_kind = ea6502_pkg::KIND_READ;
          result.address     = state_nxt.pointer;
        end
        default: begin
          // implied and unused forms
          result.address            = 16'd0;
          result.instruction_length = 2'd1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/effective_address_6502_core.sv =====
// Each result is registered in the output stage, or the skid stage if it stalls.
// Throughput: one transaction per cycle while the skid is empty; the address adders
// sit between the accepted input and the result register, one-entry skid behind it.
// Reset (rst_n low, synchronous): output and skid stages empty, phase idle,
// pointer, low byte, held Y and pending form cleared to zero.
`default_nettype none

module effective_address_6502_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  ea6502_pkg::in_item_t     in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output ea6502_pkg::out_item_t    out_data
);

  ea6502_pkg::ea_state_t state_r;
  ea6502_pkg::ea_state_t state_nxt;
  ea6502_pkg::out_item_t calc_res;
  ea6502_pkg::out_item_t out_r;
  ea6502_pkg::out_item_t skid_r;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  logic                  in_fire;
  logic                  out_fire;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ea6502_calc u_calc (
    .item      (in_data),
    .state_cur (state_r),
    .result    (calc_res),
    .state_nxt (state_nxt)
  );

  // Resolution state advances on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{pending_form: 4'd0, phase: ea6502_pkg::PH_IDLE,
                   pointer: 16'd0, low_byte: 8'd0, held_y: 8'd0};
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register and skid stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= calc_res;
      end else begin
        out_r <= calc_res;
      end
    end
  end

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a transaction while output stage is empty");

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r.phase))
    else $error("phase register lost its one-hot code");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.result_kind == ea6502_pkg::KIND_READ
                     || out_r.result_kind == ea6502_pkg::KIND_FINAL
                     || out_r.result_kind == ea6502_pkg::KIND_ERROR))
    else $error("illegal result kind presented");

  a_error_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.mode == ea6502_pkg::MODE_DATA
     && state_r.phase == ea6502_pkg::PH_IDLE)
    |=> $stable(state_r))
    else $error("stray data transaction changed resolution state");

endmodule

`default_nettype wire

// ===== tb/ea6502_checker.sv =====
`timescale 1ns / 1ps

module ea6502_checker (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire                    in_ready,
  input  ea6502_pkg::in_item_t   in_data,
  input  wire                    out_valid,
  input  wire                    out_ready,
  input  ea6502_pkg::out_item_t  out_data,
  output int                     fail_count,
  output int                     waiting,
  output int                     results_checked,
  output int                     reads_seen,
  output int                     errors_seen
);

  localparam int MAX_REPORTS = 10;

  // Shadow copy of the indirect sequencer
  logic [3:0]         pend_form;
  ea6502_pkg::phase_t seq_phase;
  logic [15:0]        ptr;
  logic [7:0]         lo_byte;
  logic [7:0]         saved_y;

  ea6502_pkg::out_item_t ea_results_due[$];
  int                    misses;
  int                    n_checked;
  int                    n_reads;
  int                    n_errors;

  function automatic logic [1:0] bytes_for_form(input logic [3:0] form);
    case (form) inside
      ea6502_pkg::FORM_IMM, ea6502_pkg::FORM_ZP, ea6502_pkg::FORM_ZP_X,
      ea6502_pkg::FORM_ZP_Y, ea6502_pkg::FORM_REL, ea6502_pkg::FORM_IND_X,
      ea6502_pkg::FORM_IND_Y:
        return 2'd2;
      ea6502_pkg::FORM_ABS, ea6502_pkg::FORM_ABS_X, ea6502_pkg::FORM_ABS_Y,
      ea6502_pkg::FORM_IND:
        return 2'd3;
      default:
        return 2'd1;
    endcase
  endfunction

  // Effective address (or read request) for one transaction; updates the shadow state
  function automatic ea6502_pkg::out_item_t resolve_ea(input ea6502_pkg::in_item_t t);
    ea6502_pkg::out_item_t r;
    logic [15:0]           base;
    logic [15:0]           sum;
    r.result_kind        = ea6502_pkg::KIND_FINAL;
    r.address            = 16'h0000;
    r.extra_cycles       = 1'b0;
    r.instruction_length = bytes_for_form(t.address_form);
    if (t.mode == ea6502_pkg::MODE_DATA) begin
      r.instruction_length = bytes_for_form(pend_form);
      if (seq_phase == ea6502_pkg::PH_LOW) begin
        // high byte comes from the same page as the low byte
        r.result_kind = ea6502_pkg::KIND_READ;
        r.address     = {ptr[15:8], ptr[7:0] + 8'd1};
        lo_byte       = t.read_data;
        seq_phase     = ea6502_pkg::PH_HIGH;
      end else if (seq_phase == ea6502_pkg::PH_HIGH) begin
        base      = {t.read_data, lo_byte};
        seq_phase = ea6502_pkg::PH_IDLE;
        if (pend_form == ea6502_pkg::FORM_IND_Y) begin
          sum            = base + {8'h00, saved_y};
          r.address      = sum;
          r.extra_cycles = (sum[15:8] != base[15:8]);
        end else begin
          r.address = base;
        end
      end else begin
        // stray data byte, state untouched
        r.result_kind        = ea6502_pkg::KIND_ERROR;
        r.instruction_length = 2'd1;
      end
      return r;
    end
    // a start always drops any pending resolution
    seq_phase = ea6502_pkg::PH_IDLE;
    case (t.address_form) inside
      ea6502_pkg::FORM_ACCUM: r.address = {8'h00, t.accumulator};
      ea6502_pkg::FORM_IMM, ea6502_pkg::FORM_ZP: r.address = {8'h00, t.operand[7:0]};
      ea6502_pkg::FORM_ZP_X: begin
        r.address      = {8'h00, t.operand[7:0] + t.index_x};
        r.extra_cycles = 1'b1;
      end
      ea6502_pkg::FORM_ZP_Y: begin
        r.address      = {8'h00, t.operand[7:0] + t.index_y};
        r.extra_cycles = 1'b1;
      end
      ea6502_pkg::FORM_ABS: r.address = t.operand;
      ea6502_pkg::FORM_ABS_X: begin
        sum            = t.operand + {8'h00, t.index_x};
        r.address      = sum;
        r.extra_cycles = (sum[15:8] != t.operand[15:8]);
      end
      ea6502_pkg::FORM_ABS_Y: begin
        sum            = t.operand + {8'h00, t.index_y};
        r.address      = sum;
        r.extra_cycles = (sum[15:8] != t.operand[15:8]);
      end
      ea6502_pkg::FORM_REL:
        r.address = t.program_counter + {{8{t.operand[7]}}, t.operand[7:0]};
      ea6502_pkg::FORM_IND, ea6502_pkg::FORM_IND_X, ea6502_pkg::FORM_IND_Y: begin
        pend_form = t.address_form;
        saved_y   = t.index_y;
        if (t.address_form == ea6502_pkg::FORM_IND)
          ptr = t.operand;
        else if (t.address_form == ea6502_pkg::FORM_IND_X)
          ptr = {8'h00, t.operand[7:0] + t.index_x};
        else
          ptr = {8'h00, t.operand[7:0]};
        seq_phase     = ea6502_pkg::PH_LOW;
        r.result_kind = ea6502_pkg::KIND_READ;
        r.address     = ptr;
      end
      default: begin
        // implied and the unused forms
        r.address            = 16'h0000;
        r.instruction_length = 2'd1;
      end
    endcase
    return r;
  endfunction

  task automatic log_miss(input string msg);
    misses++;
    if (misses <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Compare results as they leave, predict as transactions enter
  always @(posedge clk) begin : watch_channels
    ea6502_pkg::out_item_t want;
    if (!rst_n) begin
      pend_form = 4'd0;
      seq_phase = ea6502_pkg::PH_IDLE;
      ptr       = 16'h0000;
      lo_byte   = 8'h00;
      saved_y   = 8'h00;
      ea_results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (out_data.result_kind == ea6502_pkg::KIND_READ)
          n_reads++;
        if (out_data.result_kind == ea6502_pkg::KIND_ERROR)
          n_errors++;
        if (ea_results_due.size() == 0) begin
          log_miss($sformatf("unexpected result kind=%0d addr=%h extra=%0d len=%0d",
                             out_data.result_kind, out_data.address,
                             out_data.extra_cycles, out_data.instruction_length));
        end else begin
          want = ea_results_due.pop_front();
          if (out_data.result_kind !== want.result_kind ||
              out_data.address !== want.address ||
              out_data.extra_cycles !== want.extra_cycles ||
              out_data.instruction_length !== want.instruction_length)
            log_miss($sformatf(
              "expected kind=%0d addr=%h extra=%0d len=%0d, got kind=%0d addr=%h extra=%0d len=%0d",
              want.result_kind, want.address, want.extra_cycles, want.instruction_length,
              out_data.result_kind, out_data.address, out_data.extra_cycles,
              out_data.instruction_length));
        end
      end
      if (in_valid && in_ready)
        ea_results_due.push_back(resolve_ea(in_data));
    end
    // published after the edge so readers see a settled value
    waiting         <= ea_results_due.size();
    fail_count      <= misses;
    results_checked <= n_checked;
    reads_seen      <= n_reads;
    errors_seen     <= n_errors;
  end

  initial begin
    misses          = 0;
    n_checked       = 0;
    n_reads         = 0;
    n_errors        = 0;
    waiting         = 0;
    fail_count      = 0;
    results_checked = 0;
    reads_seen      = 0;
    errors_seen     = 0;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEMS       = 600;
  localparam int HOLD_CYCLES = 80;
  localparam int STUCK_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  ea6502_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  ea6502_pkg::out_item_t out_data;

  int fail_count;
  int waiting;
  int results_checked;
  int reads_seen;
  int errors_seen;

  int n_sent;
  int n_starts;
  int n_bytes;
  int hold_asks;
  int stuck_cycles;
  bit calm;

  effective_address_6502_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ea6502_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .waiting         (waiting),
    .results_checked (results_checked),
    .reads_seen      (reads_seen),
    .errors_seen     (errors_seen)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Operand biased toward the end of a page to provoke page crosses
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(99) < 30)
      w[7:0] = 8'hF8 | 8'($urandom_range(7));
    return w;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(99) < 15)
      b = $urandom_range(1) ? 8'hFF : 8'h00;
    return b;
  endfunction

  // Offer one transaction and wait for it to be taken
  task automatic push_item(input ea6502_pkg::in_item_t item);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    n_sent++;
  endtask

  task automatic send_start(input logic [3:0] form, input logic [15:0] op,
                            input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] a, input logic [15:0] pc);
    ea6502_pkg::in_item_t t;
    t.mode            = ea6502_pkg::MODE_START;
    t.address_form    = form;
    t.operand         = op;
    t.index_x         = x;
    t.index_y         = y;
    t.accumulator     = a;
    t.program_counter = pc;
    t.read_data       = 8'($urandom);
    push_item(t);
    n_starts++;
  endtask

  // Memory byte returned; the other fields carry noise
  task automatic send_data(input logic [7:0] value);
    ea6502_pkg::in_item_t t;
    logic [95:0]          noise;
    noise             = {$urandom, $urandom, $urandom};
    t                 = noise[$bits(ea6502_pkg::in_item_t)-1:0];
    t.mode            = ea6502_pkg::MODE_DATA;
    t.read_data       = value;
    push_item(t);
    n_bytes++;
  endtask

  // Result side: random backpressure plus requested long hold-offs
  initial begin : result_sink
    int hold_served;
    hold_served = 0;
    out_ready   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks > hold_served) begin
        hold_served++;
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
    end
  end

  // Watchdog on transactions in either direction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, waiting);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int          pick;
    logic [3:0]  form;
    bit          hold_asked;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    hold_asks    = 0;
    stuck_cycles = 0;
    n_sent       = 0;
    n_starts     = 0;
    n_bytes      = 0;
    hold_asked   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stray data, every form, wrap and page-cross corners
    send_data(8'hA5);
    send_start(ea6502_pkg::FORM_IMPLIED, pick_word(), pick_byte(), pick_byte(),
               pick_byte(), pick_word());
    send_start(ea6502_pkg::FORM_ACCUM, 16'h0000, 8'h00, 8'h00, 8'hFF, 16'h0000);
    send_start(ea6502_pkg::FORM_IMM, 16'hABFF, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_start(ea6502_pkg::FORM_ZP, 16'h0000, 8'hFF, 8'hFF, 8'h00, 16'hFFFF);
    send_start(ea6502_pkg::FORM_ZP_X, 16'h55F0, 8'h20, 8'h00, 8'h00, 16'h0000);
    send_start(ea6502_pkg::FORM_ZP_Y, 16'h00FF, 8'h00, 8'hFF, 8'h00, 16'h0000);
    send_start(ea6502_pkg::FORM_ABS, 16'hFFFF, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_start(ea6502_pkg::FORM_ABS_X, 16'h12F0, 8'h20, 8'h00, 8'h00, 16'h0000);
    send_start(ea6502_pkg::FORM_ABS_X, 16'hFFFF, 8'h01, 8'h00, 8'h00, 16'h0000);
    send_start(ea6502_pkg::FORM_ABS_Y, 16'h1200, 8'hFF, 8'h7F, 8'h00, 16'h0000);
    send_start(ea6502_pkg::FORM_REL, 16'h0080, 8'h00, 8'h00, 8'h00, 16'h0010);
    send_start(ea6502_pkg::FORM_REL, 16'hFF7F, 8'h00, 8'h00, 8'h00, 16'hFFFF);
    // indirect with the page-wrap quirk
    send_start(ea6502_pkg::FORM_IND, 16'h12FF, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_data(8'h34);
    send_data(8'h56);
    // (zp,X) pointer at the top of zero page
    send_start(ea6502_pkg::FORM_IND_X, 16'h00FF, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_data(8'h00);
    send_data(8'h80);
    // (zp),Y with a page cross
    send_start(ea6502_pkg::FORM_IND_Y, 16'h0040, 8'h00, 8'hFF, 8'h00, 16'h0000);
    send_data(8'hF0);
    send_data(8'h12);
    // start while busy drops the pending pointer, so the next byte is stray
    send_start(ea6502_pkg::FORM_IND_Y, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_start(ea6502_pkg::FORM_ABS, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_data(8'h77);
    send_start(4'd13, pick_word(), pick_byte(), pick_byte(), pick_byte(), pick_word());
    send_start(4'd15, pick_word(), pick_byte(), pick_byte(), pick_byte(), pick_word());

    // Random: mostly complete indirect sequences, some broken ones and noise
    while (n_sent < ITEMS) begin
      if (n_sent >= 200 && !hold_asked) begin
        hold_asks  <= hold_asks + 1;
        hold_asked  = 1'b1;
      end
      calm <= (n_sent >= 320 && n_sent < 420);
      pick = $urandom_range(99);
      if (pick < 45) begin
        form = ea6502_pkg::FORM_IND + 4'($urandom_range(2));
        send_start(form, pick_word(), pick_byte(), pick_byte(), pick_byte(), pick_word());
        pick = $urandom_range(99);
        if (pick < 80) begin
          send_data(pick_byte());
          send_data(pick_byte());
        end else if (pick < 90) begin
          send_data(pick_byte());
        end
      end else if (pick < 92) begin
        form = 4'($urandom_range(15));
        send_start(form, pick_word(), pick_byte(), pick_byte(), pick_byte(), pick_word());
      end else begin
        send_data(pick_byte());
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow the output stages to settle
    @(posedge clk);
    while (waiting != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Run covered %0d transactions (%0d starts, %0d data bytes), one long stall.",
             n_sent, n_starts, n_bytes);
    $display("Checked %0d results: %0d read requests, %0d stray-data errors, %0d mismatches.",
             results_checked, reads_seen, errors_seen, fail_count);
    if (fail_count == 0 && waiting == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== effective_address_6502_core.f =====
sv/ea6502_pkg.sv
sv/ea6502_calc.sv
sv/effective_address_6502_core.sv
tb/ea6502_checker.sv
tb/tb_top.sv
